@@ rtl/besd_pkg.sv @@
// Shared types and codes for the byte escape sequence decoder.
package besd_pkg;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_OCT,
        MODE_HEXWAIT,
        MODE_HEX,
        MODE_TAIL
    } mode_t;

    // Result kinds carried in out_kind.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_QUOTE = 2'd1;
    localparam logic [1:0] KIND_TAIL  = 2'd2;

    // Most results one input beat can cause.
    localparam int         RES_DEPTH = 5;
    localparam logic [2:0] RES_MAX   = 3'(RES_DEPTH);

    // Input beat.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       run_last;
        logic       stream_end;
    } out_beat_t;

    // Everything one input beat produces: its result list and the next parser state.
    typedef struct packed {
        logic [RES_DEPTH-1:0][7:0] res_byte;
        logic [RES_DEPTH-1:0][1:0] res_kind;
        logic [2:0]                count;
        mode_t                     mode;
        logic [31:0]               accum;
        logic [7:0]                held;
    } step_t;

endpackage

@@ rtl/besd_decode.sv @@
// Combinational step logic: decodes one input byte against the parser state.
module besd_decode (
    input  besd_pkg::mode_t    mode_cur,
    input  logic [31:0]        accum_cur,
    input  logic [7:0]         held_cur,
    input  logic               stop_sq,
    input  besd_pkg::in_beat_t beat,
    output besd_pkg::step_t    step
);
    import besd_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_SIX    = 8'h36;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_T_LO   = 8'h74;
    localparam logic [7:0] CH_V_LO   = 8'h76;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_UP   = 8'h55;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;

    // Appends one result if there is room.
    function automatic step_t push(step_t s, logic [7:0] b, logic [1:0] k);
        step_t r;
        r = s;
        if (r.count < RES_MAX)
        begin
            r.res_byte[r.count] = b;
            r.res_kind[r.count] = k;
            r.count             = r.count + 3'd1;
        end
        return r;
    endfunction

    // Hex digit test: bit 4 says the byte is a digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_val(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_ZERO && b <= CH_NINE)
            r = {1'b1, 4'(b - CH_ZERO)};
        else if (b >= CH_A_LO && b <= CH_F_LO)
            r = {1'b1, 4'(b - CH_A_LO + 8'd10)};
        else if (b >= CH_A_UP && b <= CH_F_UP)
            r = {1'b1, 4'(b - CH_A_UP + 8'd10)};
        return r;
    endfunction

    // Sends the hex value out low byte first until the rest is zero.
    function automatic step_t flush_hex(step_t s);
        step_t       r;
        logic [31:0] v;
        r = s;
        v = s.accum;
        for (int k = 0; k < 4; k++)
        begin
            if (k == 0 || (v >> (8 * k)) != 32'd0)
                r = push(r, v[8*k +: 8], KIND_DATA);
        end
        return r;
    endfunction

    function automatic step_t plain_byte(step_t s, logic [7:0] b, logic sq);
        step_t r;
        r = s;
        if (b == CH_BSLASH)
        begin
            r.mode = MODE_ESC;
        end
        else if (b == CH_DQUOTE || (b == CH_SQUOTE && sq))
        begin
            r      = push(r, b, KIND_QUOTE);
            r.mode = MODE_TAIL;
        end
        else
        begin
            r      = push(r, b, KIND_DATA);
            r.mode = MODE_TEXT;
        end
        return r;
    endfunction

    function automatic step_t escaped_byte(step_t s, logic [7:0] b);
        step_t r;
        r      = s;
        r.mode = MODE_TEXT;
        case (b)
            CH_ZERO: r = push(r, 8'h00, KIND_DATA);
            CH_A_LO: r = push(r, 8'h07, KIND_DATA);
            CH_B_LO: r = push(r, 8'h08, KIND_DATA);
            CH_F_LO: r = push(r, 8'h0C, KIND_DATA);
            CH_N_LO: r = push(r, 8'h0A, KIND_DATA);
            CH_R_LO: r = push(r, 8'h0D, KIND_DATA);
            CH_T_LO: r = push(r, 8'h09, KIND_DATA);
            CH_V_LO: r = push(r, 8'h0B, KIND_DATA);
            CH_ONE, CH_TWO, CH_THREE, CH_FOUR, CH_FIVE, CH_SIX, CH_SEVEN:
            begin
                r.accum = {29'd0, b[2:0]};
                r.mode  = MODE_OCT;
            end
            CH_X_LO, CH_U_LO, CH_U_UP:
            begin
                r.held = b;
                r.mode = MODE_HEXWAIT;
            end
            default: r = push(r, b, KIND_DATA);
        endcase
        return r;
    endfunction

    logic [4:0] hv;
    logic       is_oct;
    step_t      s;

    assign hv     = hex_val(beat.in_byte);
    assign is_oct = (beat.in_byte >= CH_ZERO) && (beat.in_byte <= CH_SEVEN);

    always_comb
    begin
        s       = '0;
        s.mode  = mode_cur;
        s.accum = accum_cur;
        s.held  = held_cur;

        case (mode_cur)
            MODE_TAIL: s = push(s, beat.in_byte, KIND_TAIL);
            MODE_ESC:  s = escaped_byte(s, beat.in_byte);
            MODE_OCT:
            begin
                if (is_oct)
                    s.accum = {24'd0, s.accum[4:0], beat.in_byte[2:0]};
                else
                begin
                    s = push(s, s.accum[7:0], KIND_DATA);
                    s = plain_byte(s, beat.in_byte, stop_sq);
                end
            end
            MODE_HEXWAIT:
            begin
                if (hv[4])
                begin
                    s.accum = {28'd0, hv[3:0]};
                    s.mode  = MODE_HEX;
                end
                else
                begin
                    s = push(s, CH_BSLASH, KIND_DATA);
                    s = push(s, s.held, KIND_DATA);
                    s = plain_byte(s, beat.in_byte, stop_sq);
                end
            end
            MODE_HEX:
            begin
                if (hv[4])
                    s.accum = {s.accum[27:0], hv[3:0]};
                else
                begin
                    s = flush_hex(s);
                    s = plain_byte(s, beat.in_byte, stop_sq);
                end
            end
            default: s = plain_byte(s, beat.in_byte, stop_sq);
        endcase

        // At the end of the buffer any open escape goes out as it stands.
        if (beat.in_last)
        begin
            case (s.mode)
                MODE_ESC: s = push(s, CH_BSLASH, KIND_DATA);
                MODE_OCT: s = push(s, s.accum[7:0], KIND_DATA);
                MODE_HEXWAIT:
                begin
                    s = push(s, CH_BSLASH, KIND_DATA);
                    s = push(s, s.held, KIND_DATA);
                end
                MODE_HEX: s = flush_hex(s);
                default:  s = s;
            endcase
            s.mode  = MODE_TEXT;
            s.accum = 32'd0;
            s.held  = 8'd0;
        end
    end

    assign step = s;

endmodule

@@ rtl/byte_escape_sequence_decoder.sv @@
// Top level of the byte escape sequence decoder: input register, step logic, result buffer.
//
//   Channel  Direction  Handshake            Payload
//   rx       in         rx_valid / rx_stall  in_beat_t  (in_byte, in_last)
//   tx       out        tx_valid / tx_stall  out_beat_t (out_byte, out_kind, run_last,
//                                                        stream_end)
//   cfg      in         cfg_valid/cfg_ready  cfg_data   (stop_on_single_quote)
//
// An input beat lands in an input register. From there the step logic decodes it
// against the parser state and, when the result buffer is free, loads all its results
// (zero to five) into the buffer and updates the state. The buffer sends one beat per
// cycle while tx does not stall, so the input takes one byte per cycle when each byte
// yields at most one result; after a byte that yields more (hex flushes, end of buffer)
// the next byte waits in the input register until all but one of those results are sent.
// Reset clears the parser state, the configuration register and both valid flags; no clearing pass.
// A stall on tx holds the buffer, and rx stalls once the input register is full and the
// buffer cannot take its results.
module byte_escape_sequence_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  besd_pkg::in_beat_t   rx_data,
    output logic                 tx_valid,
    input  logic                 tx_stall,
    output besd_pkg::out_beat_t  tx_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import besd_pkg::*;

    // Input register.
    logic                     in_vld_reg;
    in_beat_t                 in_beat_reg;

    // Parser state and the one configuration register.
    mode_t                    mode_reg;
    logic [31:0]              accum_reg;
    logic [7:0]               held_reg;
    logic                     stop_sq_reg;

    // Result buffer: entry 0 is the beat on tx; rem_reg counts entries still to send.
    logic [RES_DEPTH-1:0][7:0] buf_byte_reg;
    logic [RES_DEPTH-1:0][1:0] buf_kind_reg;
    logic [2:0]               rem_reg;
    logic                     end_reg;

    step_t                    step;
    logic                     rx_take;
    logic                     tx_take;
    logic                     buf_free;
    logic                     load;

    besd_decode u_decode (
        .mode_cur  (mode_reg),
        .accum_cur (accum_reg),
        .held_cur  (held_reg),
        .stop_sq   (stop_sq_reg),
        .beat      (in_beat_reg),
        .step      (step)
    );

    // The buffer can take a new burst when it is empty or its final beat leaves now.
    assign tx_take  = tx_valid && !tx_stall;
    assign buf_free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && tx_take);
    assign load     = in_vld_reg && buf_free;

    assign rx_stall = in_vld_reg && !load;
    assign rx_take  = rx_valid && !rx_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (load)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_beat_reg <= rx_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            accum_reg <= 32'd0;
            held_reg  <= 8'd0;
        end
        else if (load)
        begin
            mode_reg  <= step.mode;
            accum_reg <= step.accum;
            held_reg  <= step.held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_sq_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stop_sq_reg <= cfg_data;
        end
    end

    // Result buffer control: a load replaces the buffer, a sent beat shifts it down.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
        end
        else if (load)
        begin
            rem_reg <= step.count;
        end
        else if (tx_take)
        begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_byte_reg <= step.res_byte;
            buf_kind_reg <= step.res_kind;
            end_reg      <= in_beat_reg.in_last;
        end
        else if (tx_take)
        begin
            for (int k = 0; k < RES_DEPTH - 1; k++)
            begin
                buf_byte_reg[k] <= buf_byte_reg[k+1];
                buf_kind_reg[k] <= buf_kind_reg[k+1];
            end
        end
    end

    assign tx_valid            = (rem_reg != 3'd0);
    assign tx_data.out_byte    = buf_byte_reg[0];
    assign tx_data.out_kind    = buf_kind_reg[0];
    assign tx_data.run_last    = (rem_reg == 3'd1);
    assign tx_data.stream_end  = (rem_reg == 3'd1) && end_reg;

endmodule

@@ rtl/besd_check.sv @@
// Port-level checker for the byte escape sequence decoder, bound to the top level.
module besd_check (
    input logic                clk,
    input logic                rst_n,
    input logic                tx_valid,
    input logic                tx_stall,
    input besd_pkg::out_beat_t tx_data
);
    import besd_pkg::*;

    // A stalled result beat stays and keeps its payload.
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_stall |=> tx_valid && $stable(tx_data))
        else $error("stalled tx beat changed");

    // The end of the whole buffer is always the last result of its byte.
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_data.stream_end |-> tx_data.run_last)
        else $error("stream_end without run_last");

    // A terminating quote closes the results of its byte.
    a_quote_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_data.out_kind == KIND_QUOTE |-> tx_data.run_last)
        else $error("terminating quote not last result of its byte");

    // Only the three defined kinds appear.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> tx_data.out_kind == KIND_DATA || tx_data.out_kind == KIND_QUOTE
                     || tx_data.out_kind == KIND_TAIL)
        else $error("undefined out_kind");

endmodule

bind byte_escape_sequence_decoder besd_check u_besd_check (.*);

@@ verif/besd_checker.sv @@
// Checker for the byte escape sequence decoder: predicts each decoded beat and compares it.
`timescale 1ns / 100ps

module besd_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    input  logic                 rx_stall,
    input  besd_pkg::in_beat_t   rx_data,
    input  logic                 tx_valid,
    input  logic                 tx_stall,
    input  besd_pkg::out_beat_t  tx_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,
    output int                   error_count,
    output int                   pending_count
);
    import besd_pkg::*;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] DQUOTE    = 8'h22;
    localparam logic [7:0] SQUOTE    = 8'h27;

    // Decoder state as seen by the predictor.
    mode_t       cur_mode;
    logic [31:0] run_value;
    logic [7:0]  esc_letter;
    logic        single_quote_ends;

    // Results of the beat being decoded, then the queue of decoded beats still to come.
    logic [7:0]  step_byte [RES_DEPTH];
    logic [1:0]  step_kind [RES_DEPTH];
    int          step_count;
    out_beat_t   decoded_beats [$];
    out_beat_t   want;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void put_result(input logic [7:0] b, input logic [1:0] kind);
        if (step_count < RES_DEPTH)
        begin
            step_byte[step_count] = b;
            step_kind[step_count] = kind;
            step_count++;
        end
    endfunction

    // A hex run goes out low byte first; a zero value still gives one byte.
    function automatic void put_run_value();
        logic [31:0] v;
        v = run_value;
        put_result(v[7:0], KIND_DATA);
        v = v >> 8;
        while (v != 32'd0)
        begin
            put_result(v[7:0], KIND_DATA);
            v = v >> 8;
        end
    endfunction

    function automatic void text_byte(input logic [7:0] b);
        if (b == BACKSLASH)
            cur_mode = MODE_ESC;
        else if (b == DQUOTE || (b == SQUOTE && single_quote_ends))
        begin
            put_result(b, KIND_QUOTE);
            cur_mode = MODE_TAIL;
        end
        else
        begin
            put_result(b, KIND_DATA);
            cur_mode = MODE_TEXT;
        end
    endfunction

    function automatic void decode_beat(input in_beat_t beat);
        logic [7:0] b;
        int         d;
        out_beat_t  res;
        b = beat.in_byte;
        step_count = 0;
        case (cur_mode)
            MODE_TAIL: put_result(b, KIND_TAIL);
            MODE_ESC:
            begin
                cur_mode = MODE_TEXT;
                case (b)
                    "0": put_result(8'h00, KIND_DATA);
                    "a": put_result(8'h07, KIND_DATA);
                    "b": put_result(8'h08, KIND_DATA);
                    "f": put_result(8'h0C, KIND_DATA);
                    "n": put_result(8'h0A, KIND_DATA);
                    "r": put_result(8'h0D, KIND_DATA);
                    "t": put_result(8'h09, KIND_DATA);
                    "v": put_result(8'h0B, KIND_DATA);
                    "1", "2", "3", "4", "5", "6", "7":
                    begin
                        run_value = 32'(b - "0");
                        cur_mode = MODE_OCT;
                    end
                    "x", "u", "U":
                    begin
                        esc_letter = b;
                        cur_mode = MODE_HEXWAIT;
                    end
                    default: put_result(b, KIND_DATA);
                endcase
            end
            MODE_OCT:
            begin
                if (b >= "0" && b <= "7")
                    run_value = (run_value * 32'd8 + 32'(b - "0")) & 32'hFF;
                else
                begin
                    put_result(run_value[7:0], KIND_DATA);
                    text_byte(b);
                end
            end
            MODE_HEXWAIT:
            begin
                d = hex_digit(b);
                if (d >= 0)
                begin
                    run_value = 32'(d);
                    cur_mode = MODE_HEX;
                end
                else
                begin
                    put_result(BACKSLASH, KIND_DATA);
                    put_result(esc_letter, KIND_DATA);
                    text_byte(b);
                end
            end
            MODE_HEX:
            begin
                d = hex_digit(b);
                if (d >= 0)
                    run_value = (run_value << 4) | 32'(d);
                else
                begin
                    put_run_value();
                    text_byte(b);
                end
            end
            default: text_byte(b);
        endcase

        // The end of a buffer flushes whatever escape is still open.
        if (beat.in_last)
        begin
            case (cur_mode)
                MODE_ESC: put_result(BACKSLASH, KIND_DATA);
                MODE_OCT: put_result(run_value[7:0], KIND_DATA);
                MODE_HEXWAIT:
                begin
                    put_result(BACKSLASH, KIND_DATA);
                    put_result(esc_letter, KIND_DATA);
                end
                MODE_HEX: put_run_value();
                default: ;
            endcase
            cur_mode = MODE_TEXT;
            run_value = 32'd0;
            esc_letter = 8'd0;
        end

        for (int k = 0; k < step_count; k++)
        begin
            res.out_byte   = step_byte[k];
            res.out_kind   = step_kind[k];
            res.run_last   = (k == step_count - 1);
            res.stream_end = (k == step_count - 1) && beat.in_last;
            decoded_beats.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode = MODE_TEXT;
            run_value = 32'd0;
            esc_letter = 8'd0;
            single_quote_ends = 1'b0;
            error_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                single_quote_ends = cfg_data;

            // An output beat can never belong to an input beat taken at the same edge.
            if (tx_valid && !tx_stall)
            begin
                if (decoded_beats.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected output beat, expected none, actual byte %h kind %0d",
                             $time, tx_data.out_byte, tx_data.out_kind);
                end
                else
                begin
                    want = decoded_beats.pop_front();
                    if (tx_data !== want)
                    begin
                        error_count++;
                        $display("%0t: mismatch, expected byte %h kind %0d run_last %b end %b",
                                 $time, want.out_byte, want.out_kind, want.run_last,
                                 want.stream_end);
                        $display("%0t:           actual byte %h kind %0d run_last %b end %b",
                                 $time, tx_data.out_byte, tx_data.out_kind, tx_data.run_last,
                                 tx_data.stream_end);
                    end
                end
            end

            if (rx_valid && !rx_stall)
                decode_beat(rx_data);

            pending_count = decoded_beats.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the byte escape sequence decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import besd_pkg::*;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] DQUOTE    = 8'h22;
    localparam logic [7:0] SQUOTE    = 8'h27;

    // Character sets for building escape sequences.
    localparam logic [63:0]  SIMPLE_ESC  = "0abfnrtv";
    localparam logic [23:0]  HEX_LETTERS = "xuU";
    localparam logic [175:0] HEX_DIGITS  = "0123456789abcdefABCDEF";

    // Every input of the block starts at a known value.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    in_beat_t   rx_data = '0;
    logic       tx_valid;
    logic       tx_stall = 1'b0;
    out_beat_t  tx_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    int         error_count;
    int         pending_count;

    // Idling rates in percent of cycles, and a long receiver hold-off in cycles.
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         stall_burst = 0;
    int         beats_sent = 0;

    // Raw bytes of the buffer being built.
    logic [7:0] text_q [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_escape_sequence_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_data   (rx_data),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_data   (tx_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // The checker watches all three channels and keeps its own copy of the decoder state.
    besd_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_data       (rx_data),
        .tx_valid      (tx_valid),
        .tx_stall      (tx_stall),
        .tx_data       (tx_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Offer one input beat, starting at a falling edge, and return at the falling edge after
    // it was taken. Idle cycles come before the beat, so valid only drops between beats and
    // a beat that is held under stall keeps its payload.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= '{in_byte: b, in_last: last};
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Send a string, with the last flag on its final byte when asked.
    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Hold the input back until every predicted beat has come out. A beat that yields no
    // result may still sit in the block, so the task goes on waiting after the queue empties.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The block is idle whenever this is called.
    task automatic write_config(input logic single_quote_stop);
        cfg_valid <= 1'b1;
        cfg_data  <= single_quote_stop;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char(input logic [175:0] chars, input int count);
        int k;
        k = $urandom_range(count - 1);
        return chars[8*k +: 8];
    endfunction

    // Append one piece of escaped text. Pieces are raw noise, well-formed escapes with random
    // content, a backslash before a random byte or a bare hex letter, quotes and lone backslashes.
    task automatic add_fragment();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30)
            text_q.push_back(8'($urandom_range(32, 126)));
        else if (pick < 45)
        begin
            text_q.push_back(BACKSLASH);
            text_q.push_back(pick_char(SIMPLE_ESC, 8));
        end
        else if (pick < 55)
        begin
            text_q.push_back(BACKSLASH);
            text_q.push_back(8'($urandom_range(255)));
        end
        else if (pick < 67)
        begin
            text_q.push_back(BACKSLASH);
            text_q.push_back(8'(8'h31 + $urandom_range(6)));
            n = $urandom_range(3);
            repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(7)));
        end
        else if (pick < 79)
        begin
            // Nine digits now and then, so the 32-bit value wraps.
            text_q.push_back(BACKSLASH);
            text_q.push_back(pick_char(HEX_LETTERS, 3));
            n = ($urandom_range(9) == 0) ? 9 : $urandom_range(1, 8);
            repeat (n) text_q.push_back(pick_char(HEX_DIGITS, 22));
        end
        else if (pick < 84)
        begin
            text_q.push_back(BACKSLASH);
            text_q.push_back(pick_char(HEX_LETTERS, 3));
        end
        else if (pick < 90)
            text_q.push_back(8'($urandom_range(255)));
        else if (pick < 95)
            text_q.push_back($urandom_range(1) ? DQUOTE : SQUOTE);
        else
            text_q.push_back(BACKSLASH);
    endtask

    // One buffer of random text; its final byte carries the last flag, which often lands
    // in the middle of an escape and forces a flush.
    task automatic send_buffer();
        int pieces;
        pieces = $urandom_range(1, 10);
        text_q.delete();
        repeat (pieces) add_fragment();
        foreach (text_q[i])
            send_beat(text_q[i], i == text_q.size() - 1);
    endtask

    // The receiver changes stall at falling edges. A requested hold-off is counted here,
    // cycle by cycle, while the sender keeps offering beats.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_burst > 0)
            begin
                tx_stall <= 1'b1;
                stall_burst--;
            end
            else
                tx_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        int target;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with single quotes not ending the string (reset value).
        // Raw extremes, a control escape, an escape of a plain letter, an escaped quote
        // and an unescaped single quote that stays data.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("\\n\\q\\\"'", 1'b0);
        // Octal run kept mod 256, then a hex letter without a digit.
        send_text("\\777\\xG", 1'b0);
        // Full 32-bit hex run flushed by the terminating quote: the most results per beat.
        send_text("\\U89abcdef\"", 1'b0);
        // A tail backslash is not interpreted, and the end of buffer leaves tail mode.
        send_text("\\", 1'b1);
        // Trailing backslash, then a hex letter cut off by the end of the buffer.
        send_text("\\", 1'b1);
        send_text("\\x", 1'b1);
        wait_drained();

        // Random part in three phases: sender idles a third of the time and the receiver
        // most of the time, then the other way round, then neither idles.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_config(phase != 1);
            // With both sides busy, a long receiver hold-off fills the block up.
            if (phase == 2)
                stall_burst = 80;
            target = beats_sent + 126;
            while (beats_sent < target)
                send_buffer();
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #3600000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/besd_pkg.sv
rtl/besd_decode.sv
rtl/byte_escape_sequence_decoder.sv
rtl/besd_check.sv
verif/besd_checker.sv
verif/testbench.sv
